// ===== hdl/mfpr_pkg.sv =====
// Package: item types, operation codes, register indexes and reset values.
`default_nettype none
package mfpr_pkg;

  localparam int DEFAULT_PACKET_DEPTH = 128;

  localparam int BYTE_W  = 8;
  localparam int INDEX_W = 7;
  localparam int LEN_W   = 8;

  // Operation codes
  localparam logic [1:0] OP_RX_BYTE = 2'd0;
  localparam logic [1:0] OP_CLEAR   = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;

  // Register indexes
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_HEADER     = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_FIRST_END  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_SECOND_END = 2'd2;

  localparam logic [BYTE_W-1:0] HEADER_RESET     = 8'd65;
  localparam logic [BYTE_W-1:0] FIRST_END_RESET  = 8'd66;
  localparam logic [BYTE_W-1:0] SECOND_END_RESET = 8'd67;

  typedef struct packed {
    logic [1:0]         operation;
    logic [BYTE_W-1:0]  rx_byte;
    logic [INDEX_W-1:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic              packet_ready;
    logic [LEN_W-1:0]  packet_length;
    logic [BYTE_W-1:0] read_byte;
    logic              overflow;
  } out_item_t;

  // Classified command handed from front to back
  typedef enum logic [1:0] {
    CMD_BYTE,
    CMD_CLEAR,
    CMD_READ,
    CMD_NOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [BYTE_W-1:0]  rx_byte;
    logic [INDEX_W-1:0] read_index;
  } cmd_t;

endpackage : mfpr_pkg
`default_nettype wire

// ===== hdl/mfpr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mfpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : mfpr_ram
`default_nettype wire

// ===== hdl/mfpr_front.sv =====
// Front end: accepts items, classifies the operation, two-entry command queue.
`default_nettype none
module mfpr_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire mfpr_pkg::in_item_t in_item,
  output logic                   cmd_valid,
  input  wire logic              cmd_pop,
  output mfpr_pkg::cmd_t         cmd
);
  import mfpr_pkg::*;

  cmd_t       q [2];
  logic       head;
  logic       tail;
  logic [1:0] count;
  logic       push;
  cmd_t       incoming;

  always_comb begin
    incoming.rx_byte    = in_item.rx_byte;
    incoming.read_index = in_item.read_index;
    unique case (in_item.operation)
      OP_RX_BYTE: incoming.kind = CMD_BYTE;
      OP_CLEAR:   incoming.kind = CMD_CLEAR;
      OP_READ:    incoming.kind = CMD_READ;
      default:    incoming.kind = CMD_NOP;
    endcase
  end

  assign in_ready  = (count != 2'd2);
  assign push      = in_valid && in_ready;
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[head];

  always_ff @(posedge clk) begin
    if (push) begin
      q[tail] <= incoming;
    end
    if (rst) begin
      head  <= 1'b0;
      tail  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        tail <= ~tail;
      end
      if (cmd_pop) begin
        head <= ~head;
      end
      count <= count + 2'(push) - 2'(cmd_pop);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue count out of range");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> count != 2'd0)
    else $error("pop from empty queue");
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (push && !cmd_pop) |=> count == $past(count) + 2'd1)
    else $error("push lost");

endmodule : mfpr_front
`default_nettype wire

// ===== hdl/mfpr_back.sv =====
// Back end: framing state, payload store and registered result.
`default_nettype none
module mfpr_back #(
  parameter int PACKET_DEPTH = mfpr_pkg::DEFAULT_PACKET_DEPTH
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_write,
  input  wire logic [mfpr_pkg::REG_IDX_W-1:0]    cfg_index,
  input  wire logic [mfpr_pkg::BYTE_W-1:0]       cfg_data,
  input  wire logic                              cmd_valid,
  output logic                                   cmd_pop,
  input  wire mfpr_pkg::cmd_t                    cmd,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output mfpr_pkg::out_item_t                    out_item
);
  import mfpr_pkg::*;

  localparam int AW  = $clog2(PACKET_DEPTH);
  localparam int WPW = $clog2(PACKET_DEPTH + 1);
  localparam int IW  = (AW > INDEX_W) ? AW : INDEX_W;
  localparam int CW  = (IW > WPW) ? IW : WPW;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_DATA,
    PH_TAIL
  } phase_t;

  logic [BYTE_W-1:0] header_byte;
  logic [BYTE_W-1:0] first_end_byte;
  logic [BYTE_W-1:0] second_end_byte;

  phase_t          phase, phase_next;
  logic [WPW-1:0]  wp, wp_next;
  logic            ready_flag, ready_flag_next;
  logic            ovf, ovf_next;
  logic            rd_sel, rd_sel_next;
  logic            full;
  logic            ram_we;
  logic [IW-1:0]   idx_ext;
  logic [BYTE_W-1:0] ram_q;
  logic              res_ready;
  logic [LEN_W-1:0]  res_len;
  logic              res_ovf;

  assign cmd_pop = cmd_valid && (!out_valid || out_ready);
  assign full    = (wp == WPW'(PACKET_DEPTH));
  assign idx_ext = IW'(cmd.read_index);

  always_comb begin
    phase_next      = phase;
    wp_next         = wp;
    ready_flag_next = ready_flag;
    ovf_next        = ovf;
    ram_we          = 1'b0;
    rd_sel_next     = 1'b0;
    case (cmd.kind)
      CMD_BYTE: begin
        unique case (phase)
          PH_DATA: begin
            if (cmd.rx_byte == first_end_byte) begin
              phase_next = PH_TAIL;
            end else if (!full) begin
              ram_we  = 1'b1;
              wp_next = wp + WPW'(1);
            end else begin
              ovf_next = 1'b1;
            end
          end
          PH_TAIL: begin
            if (cmd.rx_byte == second_end_byte) begin
              phase_next      = PH_IDLE;
              ready_flag_next = 1'b1;
            end
          end
          default: begin
            if (cmd.rx_byte == header_byte && !ready_flag) begin
              phase_next = PH_DATA;
              wp_next    = '0;
              ovf_next   = 1'b0;
            end
          end
        endcase
      end
      CMD_CLEAR: ready_flag_next = 1'b0;
      CMD_READ:  rd_sel_next = (CW'(cmd.read_index) < CW'(wp));
      default:   ;
    endcase
  end

  mfpr_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(PACKET_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (cmd_pop && ram_we),
    .waddr(wp[AW-1:0]),
    .wdata(cmd.rx_byte),
    .re   (cmd_pop),
    .raddr(idx_ext[AW-1:0]),
    .rdata(ram_q)
  );

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      res_ready <= ready_flag_next;
      res_len   <= LEN_W'(wp_next);
      res_ovf   <= ovf_next;
    end
    if (rst) begin
      header_byte     <= HEADER_RESET;
      first_end_byte  <= FIRST_END_RESET;
      second_end_byte <= SECOND_END_RESET;
      phase           <= PH_IDLE;
      wp              <= '0;
      ready_flag      <= 1'b0;
      ovf             <= 1'b0;
      rd_sel          <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_HEADER:     header_byte     <= cfg_data;
          REG_FIRST_END:  first_end_byte  <= cfg_data;
          REG_SECOND_END: second_end_byte <= cfg_data;
          default:        ;
        endcase
      end
      if (cmd_pop) begin
        phase      <= phase_next;
        wp         <= wp_next;
        ready_flag <= ready_flag_next;
        ovf        <= ovf_next;
        rd_sel     <= rd_sel_next;
        out_valid  <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign out_item = '{packet_ready:  res_ready,
                      packet_length: res_len,
                      read_byte:     (rd_sel ? ram_q : '0),
                      overflow:      res_ovf};

  a_wp_bound: assert property (@(posedge clk) disable iff (rst)
    wp <= WPW'(PACKET_DEPTH))
    else $error("write position past buffer depth");
  a_ovf_when_full: assert property (@(posedge clk) disable iff (rst)
    $rose(ovf) |-> $past(full))
    else $error("overflow raised with room left");
  a_ready_from_tail: assert property (@(posedge clk) disable iff (rst)
    $rose(ready_flag) |-> $past(phase) == PH_TAIL)
    else $error("ready raised outside tail phase");

endmodule : mfpr_back
`default_nettype wire

// ===== hdl/marker_framed_packet_receiver.sv =====
// Path: the back pops an item from the front queue into its result register,
//   raising out_valid; pops wait while an unread result is held.
// Throughput: one item per cycle while out_ready is high; a two-entry command
//   queue feeds the framer, paced by its result register and registered store read.
// Reset (rst, synchronous): phase, length, flags and marker registers return to
//   their reset values; the payload store is not cleared and needs no sweep.
// Store reads only reach entries written in the current packet.
`default_nettype none
module marker_framed_packet_receiver #(
  parameter int PACKET_DEPTH = mfpr_pkg::DEFAULT_PACKET_DEPTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // configuration write port
  input  wire logic                           cfg_write,
  input  wire logic [mfpr_pkg::REG_IDX_W-1:0] cfg_index,
  input  wire logic [mfpr_pkg::BYTE_W-1:0]    cfg_data,
  // item input
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire mfpr_pkg::in_item_t             in_item,
  // result output
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output mfpr_pkg::out_item_t                 out_item
);
  import mfpr_pkg::*;

  // front -> back command path
  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  // Front: takes items whenever its queue has room, decodes the operation.
  mfpr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .cmd_valid(cmd_valid),
    .cmd_pop  (cmd_pop),
    .cmd      (cmd)
  );

  // Back: runs the framing state, writes/reads the store, holds the result
  // until the item is taken; stalls only when the result register is full.
  mfpr_back #(
    .PACKET_DEPTH(PACKET_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cmd_valid(cmd_valid),
    .cmd_pop  (cmd_pop),
    .cmd      (cmd),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

endmodule : marker_framed_packet_receiver
`default_nettype wire
